/* rtl/ssoi_pkg.sv */
// Shared types, constants and table functions for the skid-steer odometry integrator.
`timescale 1ns / 1ps
package ssoi_pkg;

	// Configuration register indexes (byte address is four times the index).
	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_ROS    = 2'd1;
	localparam logic [1:0] REG_ENABLE = 2'd2;

	localparam logic [15:0] RADIUS_RESET = 16'd6554;
	localparam logic [15:0] ROS_RESET    = 16'd13945;

	// Angle of a quarter turn in binary angle units.
	localparam logic [15:0] QUARTER = 16'd16384;

	// Polynomial coefficients for the sine table, Q30.
	localparam longint Q30   = 64'sd1073741824;
	localparam longint COEF1 = 64'sd1686629713;
	localparam longint COEF3 = -64'sd693598668;
	localparam longint COEF5 = 64'sd85569306;
	localparam longint COEF7 = -64'sd5026995;
	localparam longint COEF9 = 64'sd172272;

	// 32768/pi in Q16.
	localparam logic [30:0] RAD_TO_BAM_K = 31'd683565276;

	// Odd factor shared by the 32768e6 and 1e6 divisors after their power-of-two parts.
	localparam logic [14:0] DIV_D = 15'd15625;
	localparam int unsigned DIV_W = 48;

	// Rounding offsets loaded into the accumulator before a product is added.
	localparam logic signed [63:0] BIAS_VX  = 64'sd512;
	localparam logic signed [63:0] BIAS_WZ  = 64'sd4096;
	localparam logic signed [63:0] BIAS_XY  = 64'sd16384000000;
	localparam logic signed [63:0] BIAS_RAD = 64'sd500000;
	localparam logic signed [63:0] BIAS_BAM = 64'sd34359738368;

	typedef enum logic [2:0] {
		A_SUM, A_DIFF, A_VX, A_WZ, A_PT_LO, A_PT_HI, A_RAD_LO, A_RAD_HI
	} a_sel_t;

	typedef enum logic [2:0] {
		B_RADIUS, B_ROS, B_COS, B_SIN, B_DT, B_BAM_K
	} b_sel_t;

	typedef enum logic [2:0] {
		BASE_ACC, BASE_VX, BASE_WZ, BASE_XY, BASE_RAD, BASE_BAM
	} base_sel_t;

	typedef enum logic [1:0] {
		SH_0, SH_8, SH_24
	} shift_sel_t;

	typedef enum logic {
		DIV_XY, DIV_RAD
	} div_sel_t;

	typedef struct packed {
		logic       load;
		logic       acc_we;
		a_sel_t     a_sel;
		b_sel_t     b_sel;
		base_sel_t  base;
		shift_sel_t shift;
		logic       rom_cos;
		logic       vx_we;
		logic       wz_we;
		logic       cos_we;
		logic       sin_we;
		logic       pt_we;
		logic       div_start;
		div_sel_t   div_sel;
		logic       x_we;
		logic       y_we;
		logic       rad_we;
		logic       head_we;
		logic       out_we;
		logic       upd;
	} cmd_t;

	typedef struct packed {
		logic dt_nonzero;
		logic div_busy;
	} status_t;

	function automatic longint rnd30(input longint v);
		return (v + 64'sd536870912) >>> 30;
	endfunction

	// One sine table entry for the Q30 fraction z of a quarter turn.
	function automatic logic [14:0] sine_entry(input longint z);
		longint z2;
		longint p;
		longint v;
		z2 = rnd30(z * z);
		p = COEF9;
		p = COEF7 + rnd30(p * z2);
		p = COEF5 + rnd30(p * z2);
		p = COEF3 + rnd30(p * z2);
		p = COEF1 + rnd30(p * z2);
		p = rnd30(p * z);
		v = rnd30(p * 64'sd32767);
		if (v < 0)
			v = 0;
		else if (v > 64'sd32767)
			v = 64'sd32767;
		return v[14:0];
	endfunction

endpackage

/* rtl/skid_steer_odometry_integrator_top.sv */
// Top level of the skid-steer odometry integrator: ports, register file, controller and datapath.
`timescale 1ns / 1ps
// An item that advances the pose keeps the block busy from acceptance until its result enters
// the output register; that write is held back while a previous result still waits.
// An item with integration off or zero elapsed time skips the pose steps; an incomplete item is taken in idle.
// Three divisions by 15625 (four reciprocal partial products, then the quotient is taken)
// plus the multiply steps that share one 25x31 multiplier make up the busy time.
// Reset is asynchronous and active low: it zeroes the pose and loads the register defaults.
module skid_steer_odometry_integrator_top #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	// s_tdata: left_front_speed, left_back_speed, right_front_speed, right_back_speed,
	// elapsed_us, then four zero bits.
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [87:0]  s_tdata,
	// s_tuser: all_wheels_present.
	input  logic [0:0]   s_tuser,
	// m_tdata: forward_speed, turn_rate, pose_x_out, pose_y_out, heading_out.
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,
	// m_tuser: pose_updated.
	output logic [0:0]   m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import ssoi_pkg::*;

	logic [15:0] radius_q;
	logic [15:0] ros_q;
	logic        enable_q;
	logic        cfg_write;

	cmd_t    cmd;
	status_t status;

	logic [23:0] forward_speed, turn_rate;
	logic [31:0] pose_x_out, pose_y_out;
	logic [15:0] heading_out;
	logic        pose_updated;

	// Configuration registers. Writes land on the access cycle; the bus never waits.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			ros_q    <= ROS_RESET;
			enable_q <= 1'b1;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_RADIUS: radius_q <= pwdata[15:0];
				REG_ROS:    ros_q    <= pwdata[15:0];
				REG_ENABLE: enable_q <= pwdata[0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_RADIUS: prdata = {16'd0, radius_q};
			REG_ROS:    prdata = {16'd0, ros_q};
			REG_ENABLE: prdata = {31'd0, enable_q};
			default:    prdata = '0;
		endcase
	end

	// The controller holds the block busy for the whole of one item; the output register
	// lets it take the next item while the previous result still waits downstream.
	ssoi_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.item_present    (s_tuser[0]),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.integrate_enable(enable_q),
		.status          (status),
		.cmd             (cmd)
	);

	ssoi_datapath #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.radius_cfg   (radius_q),
		.ros          (ros_q),
		.lf_speed     (s_tdata[15:0]),
		.lb_speed     (s_tdata[31:16]),
		.rf_speed     (s_tdata[47:32]),
		.rb_speed     (s_tdata[63:48]),
		.elapsed      (s_tdata[83:64]),
		.forward_speed(forward_speed),
		.turn_rate    (turn_rate),
		.pose_x_out   (pose_x_out),
		.pose_y_out   (pose_y_out),
		.heading_out  (heading_out),
		.pose_updated (pose_updated)
	);

	assign m_tdata    = {heading_out, pose_y_out, pose_x_out, turn_rate, forward_speed};
	assign m_tuser[0] = pose_updated;

`ifndef NO_ASSERTIONS
	// The shared divider is never restarted while it is still working.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !status.div_busy)
		else $error("divider started while busy");

	// A result only overwrites the output register once the previous one has gone.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_we |-> (!m_tvalid || m_tready))
		else $error("result register overwritten");

	// A complete item keeps the block busy in the following cycle.
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[0]) |=> !s_tready)
		else $error("ready right after a complete item");
`endif

endmodule

/* rtl/ssoi_sine_rom.sv */
// Quarter-wave sine table with registered read and quadrant folding.
`timescale 1ns / 1ps
module ssoi_sine_rom #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic [15:0]        angle,
	output logic signed [16:0] value
);
	import ssoi_pkg::*;

	localparam int IdxW = $clog2(SINE_TABLE_DEPTH + 1);

	logic [14:0]     rom_w [0:SINE_TABLE_DEPTH];
	logic [14:0]     phase;
	logic [31:0]     idx_full;
	logic [IdxW-1:0] idx;
	logic [14:0]     entry_q;
	logic            neg_q;

	for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_rom
		localparam longint Z = (longint'(gi) * Q30) / SINE_TABLE_DEPTH;
		assign rom_w[gi] = sine_entry(Z);
	end

	// Odd quadrants run the table backward.
	assign phase    = angle[14] ? (QUARTER[14:0] - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
	assign idx_full = ({17'd0, phase} * 32'(SINE_TABLE_DEPTH)) >> 14;
	assign idx      = idx_full[IdxW-1:0];

	always_ff @(posedge clk) begin
		entry_q <= rom_w[idx];
		neg_q   <= angle[15];
	end

	assign value = neg_q ? -$signed({2'b00, entry_q}) : $signed({2'b00, entry_q});

endmodule

/* rtl/ssoi_div.sv */
// Floor divider of a signed word by the constant 15625 through a reciprocal multiply.
`timescale 1ns / 1ps
module ssoi_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [47:0]      num,
	output logic                    busy,
	output logic signed [47:0]      quot
);
	import ssoi_pkg::*;

	// ceil(2^61 / 15625); the quotient is exact for every magnitude below 2^47.
	localparam logic [47:0] RECIP      = 48'd147573952589677;
	localparam int          RecipShift = 61;

	logic [DIV_W-1:0] mag_q;
	logic [95:0]      acc_q;
	logic [1:0]       step_q;
	logic             neg_q;
	logic             busy_q;

	logic [DIV_W-1:0] mag_start;
	logic [23:0]      op_a;
	logic [23:0]      op_b;
	logic [47:0]      pp;
	logic [95:0]      pp_sh;
	logic [47:0]      quo;

	// Floor division of a negative value works on (-n + d - 1).
	assign mag_start = num[DIV_W-1] ? ((~num) + 48'd1 + 48'(DIV_D - 15'd1)) : num;

	// The four 24x24 partial products of magnitude and reciprocal, one per cycle.
	always_comb begin
		case (step_q)
			2'd0: begin
				op_a = mag_q[23:0];
				op_b = RECIP[23:0];
			end
			2'd1: begin
				op_a = mag_q[23:0];
				op_b = RECIP[47:24];
			end
			2'd2: begin
				op_a = mag_q[47:24];
				op_b = RECIP[23:0];
			end
			default: begin
				op_a = mag_q[47:24];
				op_b = RECIP[47:24];
			end
		endcase
	end

	assign pp = op_a * op_b;

	always_comb begin
		case (step_q)
			2'd0:    pp_sh = {48'd0, pp};
			2'd3:    pp_sh = {pp, 48'd0};
			default: pp_sh = {24'd0, pp, 24'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 2'd1;
			busy_q <= (step_q != 2'd3);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag_start;
			acc_q <= '0;
			neg_q <= num[DIV_W-1];
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	assign quo   = 48'(acc_q[95:RecipShift]);
	assign busy  = busy_q;
	assign quot  = neg_q ? -$signed(quo) : $signed(quo);

endmodule

/* rtl/ssoi_datapath.sv */
// Datapath: operand registers, shared multiplier, accumulator, pose state and result register.
`timescale 1ns / 1ps
module ssoi_datapath #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ssoi_pkg::cmd_t      cmd,
	output ssoi_pkg::status_t   status,
	input  logic [15:0]         radius_cfg,
	input  logic [15:0]         ros,
	input  logic signed [15:0]  lf_speed,
	input  logic signed [15:0]  lb_speed,
	input  logic signed [15:0]  rf_speed,
	input  logic signed [15:0]  rb_speed,
	input  logic [19:0]         elapsed,
	output logic [23:0]         forward_speed,
	output logic [23:0]         turn_rate,
	output logic [31:0]         pose_x_out,
	output logic [31:0]         pose_y_out,
	output logic [15:0]         heading_out,
	output logic                pose_updated
);
	import ssoi_pkg::*;

	logic signed [16:0] lsum_q, rsum_q;
	logic [19:0]        dt_q;
	logic signed [23:0] vx_q, wz_q;
	logic signed [16:0] cos_q, sin_q;
	logic signed [40:0] pt_q;
	logic signed [47:0] rad_q;
	logic signed [63:0] acc_q;
	logic signed [31:0] x_q, y_q;
	logic [15:0]        heading_q;

	logic signed [17:0] sum_w, diff_w;
	logic signed [24:0] a_w;
	logic signed [30:0] b_w;
	logic signed [55:0] prod_w;
	logic signed [63:0] prod64_w, term_w, base_w;
	logic signed [16:0] rom_val;
	logic [15:0]        rom_angle;
	logic signed [47:0] div_num, quot;
	logic               div_busy;
	logic signed [48:0] x_sum, y_sum;

	function automatic logic [23:0] sat24(input logic signed [63:0] v);
		if (v > 64'sd8388607)
			return 24'h7FFFFF;
		if (v < -64'sd8388608)
			return 24'h800000;
		return v[23:0];
	endfunction

	function automatic logic [31:0] sat32(input logic signed [48:0] v);
		if (v > 49'sd2147483647)
			return 32'h7FFFFFFF;
		if (v < -49'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	assign sum_w  = 18'(rsum_q) + 18'(lsum_q);
	assign diff_w = 18'(rsum_q) - 18'(lsum_q);

	always_comb begin
		case (cmd.a_sel)
			A_SUM:    a_w = 25'(sum_w);
			A_DIFF:   a_w = 25'(diff_w);
			A_VX:     a_w = 25'(vx_q);
			A_WZ:     a_w = 25'(wz_q);
			A_PT_LO:  a_w = $signed({1'b0, pt_q[23:0]});
			A_PT_HI:  a_w = 25'($signed(pt_q[40:24]));
			A_RAD_LO: a_w = $signed({1'b0, rad_q[23:0]});
			A_RAD_HI: a_w = $signed({rad_q[47], rad_q[47:24]});
			default:  a_w = '0;
		endcase
	end

	always_comb begin
		case (cmd.b_sel)
			B_RADIUS: b_w = $signed({15'd0, radius_cfg});
			B_ROS:    b_w = $signed({15'd0, ros});
			B_COS:    b_w = 31'(cos_q);
			B_SIN:    b_w = 31'(sin_q);
			B_DT:     b_w = $signed({11'd0, dt_q});
			B_BAM_K:  b_w = $signed(RAD_TO_BAM_K);
			default:  b_w = '0;
		endcase
	end

	assign prod_w   = a_w * b_w;
	assign prod64_w = 64'(prod_w);

	always_comb begin
		case (cmd.shift)
			SH_8:    term_w = prod64_w <<< 8;
			SH_24:   term_w = prod64_w <<< 24;
			default: term_w = prod64_w;
		endcase
	end

	always_comb begin
		case (cmd.base)
			BASE_ACC: base_w = acc_q;
			BASE_VX:  base_w = BIAS_VX;
			BASE_WZ:  base_w = BIAS_WZ;
			BASE_XY:  base_w = BIAS_XY;
			BASE_RAD: base_w = BIAS_RAD;
			BASE_BAM: base_w = BIAS_BAM;
			default:  base_w = acc_q;
		endcase
	end

	assign rom_angle = cmd.rom_cos ? (heading_q + QUARTER) : heading_q;

	ssoi_sine_rom #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_rom (
		.clk  (clk),
		.angle(rom_angle),
		.value(rom_val)
	);

	// Position steps are divided by 2^21 and rad steps by 2^6 before the odd divide.
	assign div_num = (cmd.div_sel == DIV_RAD) ? acc_q[53:6] : {{5{acc_q[63]}}, acc_q[63:21]};

	ssoi_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.busy  (div_busy),
		.quot  (quot)
	);

	assign x_sum = 49'(x_q) + 49'(quot);
	assign y_sum = 49'(y_q) + 49'(quot);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lsum_q <= 17'(lf_speed) + 17'(lb_speed);
			rsum_q <= 17'(rf_speed) + 17'(rb_speed);
			dt_q   <= elapsed;
		end
		if (cmd.acc_we)
			acc_q <= base_w + term_w;
		if (cmd.vx_we)
			vx_q <= sat24(acc_q >>> 10);
		if (cmd.wz_we)
			wz_q <= sat24(acc_q >>> 13);
		if (cmd.cos_we)
			cos_q <= rom_val;
		if (cmd.sin_we)
			sin_q <= rom_val;
		if (cmd.pt_we)
			pt_q <= prod_w[40:0];
		if (cmd.rad_we)
			rad_q <= quot;
		if (cmd.out_we) begin
			forward_speed <= vx_q;
			turn_rate     <= wz_q;
			pose_x_out    <= x_q;
			pose_y_out    <= y_q;
			heading_out   <= heading_q;
			pose_updated  <= cmd.upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q       <= '0;
			y_q       <= '0;
			heading_q <= '0;
		end else begin
			if (cmd.x_we)
				x_q <= sat32(x_sum);
			if (cmd.y_we)
				y_q <= sat32(y_sum);
			if (cmd.head_we)
				heading_q <= heading_q + acc_q[51:36];
		end
	end

	assign status.dt_nonzero = (dt_q != 20'd0);
	assign status.div_busy   = div_busy;

endmodule

/* rtl/ssoi_ctrl.sv */
// Controller: sequences one item through the datapath and runs the handshakes.
`timescale 1ns / 1ps
module ssoi_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              item_present,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  logic              integrate_enable,
	input  ssoi_pkg::status_t status,
	output ssoi_pkg::cmd_t    cmd
);
	import ssoi_pkg::*;

	typedef enum logic [20:0] {
		ST_IDLE  = 21'h000001,
		ST_VX    = 21'h000002,
		ST_WZ    = 21'h000004,
		ST_WB    = 21'h000008,
		ST_PTC   = 21'h000010,
		ST_XLO   = 21'h000020,
		ST_XHI   = 21'h000040,
		ST_XDIV  = 21'h000080,
		ST_XWAIT = 21'h000100,
		ST_PTS   = 21'h000200,
		ST_YLO   = 21'h000400,
		ST_YHI   = 21'h000800,
		ST_YDIV  = 21'h001000,
		ST_YWAIT = 21'h002000,
		ST_WT    = 21'h004000,
		ST_HDIV  = 21'h008000,
		ST_HWAIT = 21'h010000,
		ST_KLO   = 21'h020000,
		ST_KHI   = 21'h040000,
		ST_HWB   = 21'h080000,
		ST_OUT   = 21'h100000
	} state_t;

	state_t state_q, state_n;
	logic   upd_q, upd_n;
	logic   m_tvalid_q;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		upd_n   = upd_q;
		cmd.upd = upd_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load = accept;
				if (accept && item_present)
					state_n = ST_VX;
			end
			ST_VX: begin
				cmd.acc_we  = 1'b1;
				cmd.a_sel   = A_SUM;
				cmd.b_sel   = B_RADIUS;
				cmd.base    = BASE_VX;
				cmd.rom_cos = 1'b1;
				state_n     = ST_WZ;
			end
			ST_WZ: begin
				cmd.vx_we  = 1'b1;
				cmd.cos_we = 1'b1;
				cmd.acc_we = 1'b1;
				cmd.a_sel  = A_DIFF;
				cmd.b_sel  = B_ROS;
				cmd.base   = BASE_WZ;
				state_n    = ST_WB;
			end
			ST_WB: begin
				cmd.wz_we  = 1'b1;
				cmd.sin_we = 1'b1;
				upd_n      = integrate_enable && status.dt_nonzero;
				state_n    = (integrate_enable && status.dt_nonzero) ? ST_PTC : ST_OUT;
			end
			ST_PTC: begin
				cmd.pt_we = 1'b1;
				cmd.a_sel = A_VX;
				cmd.b_sel = B_COS;
				state_n   = ST_XLO;
			end
			ST_XLO: begin
				cmd.acc_we = 1'b1;
				cmd.a_sel  = A_PT_LO;
				cmd.b_sel  = B_DT;
				cmd.base   = BASE_XY;
				state_n    = ST_XHI;
			end
			ST_XHI: begin
				cmd.acc_we = 1'b1;
				cmd.a_sel  = A_PT_HI;
				cmd.b_sel  = B_DT;
				cmd.base   = BASE_ACC;
				cmd.shift  = SH_24;
				state_n    = ST_XDIV;
			end
			ST_XDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_XY;
				state_n       = ST_XWAIT;
			end
			ST_XWAIT: begin
				if (!status.div_busy) begin
					cmd.x_we = 1'b1;
					state_n  = ST_PTS;
				end
			end
			ST_PTS: begin
				cmd.pt_we = 1'b1;
				cmd.a_sel = A_VX;
				cmd.b_sel = B_SIN;
				state_n   = ST_YLO;
			end
			ST_YLO: begin
				cmd.acc_we = 1'b1;
				cmd.a_sel  = A_PT_LO;
				cmd.b_sel  = B_DT;
				cmd.base   = BASE_XY;
				state_n    = ST_YHI;
			end
			ST_YHI: begin
				cmd.acc_we = 1'b1;
				cmd.a_sel  = A_PT_HI;
				cmd.b_sel  = B_DT;
				cmd.base   = BASE_ACC;
				cmd.shift  = SH_24;
				state_n    = ST_YDIV;
			end
			ST_YDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_XY;
				state_n       = ST_YWAIT;
			end
			ST_YWAIT: begin
				if (!status.div_busy) begin
					cmd.y_we = 1'b1;
					state_n  = ST_WT;
				end
			end
			ST_WT: begin
				cmd.acc_we = 1'b1;
				cmd.a_sel  = A_WZ;
				cmd.b_sel  = B_DT;
				cmd.base   = BASE_RAD;
				cmd.shift  = SH_8;
				state_n    = ST_HDIV;
			end
			ST_HDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_RAD;
				state_n       = ST_HWAIT;
			end
			ST_HWAIT: begin
				if (!status.div_busy) begin
					cmd.rad_we = 1'b1;
					state_n    = ST_KLO;
				end
			end
			ST_KLO: begin
				cmd.acc_we = 1'b1;
				cmd.a_sel  = A_RAD_LO;
				cmd.b_sel  = B_BAM_K;
				cmd.base   = BASE_BAM;
				state_n    = ST_KHI;
			end
			ST_KHI: begin
				cmd.acc_we = 1'b1;
				cmd.a_sel  = A_RAD_HI;
				cmd.b_sel  = B_BAM_K;
				cmd.base   = BASE_ACC;
				cmd.shift  = SH_24;
				state_n    = ST_HWB;
			end
			ST_HWB: begin
				cmd.head_we = 1'b1;
				state_n     = ST_OUT;
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_we = 1'b1;
					state_n    = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			upd_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			upd_q   <= upd_n;
			if (cmd.out_we)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

endmodule
